// File: rtl/mfpe_pkg.sv
// Package for the meter frame parser with energy integration.
// Holds shared widths, character codes, phase and status encodings and the
// frame struct. No dependencies.
`timescale 1ns / 1ps
package mfpe_pkg;

  // Field widths
  localparam int BYTE_W     = 8;
  localparam int TIME_W     = 32;
  localparam int VALUE_W    = 20;
  localparam int COUNT_W    = 8;
  localparam int LIMIT_W    = 9;
  localparam int ENERGY_W   = 64;
  localparam int PRODUCT_W  = VALUE_W + TIME_W;
  localparam int MAX_FIELDS = 18;

  // Stream payload widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 112;
  localparam int OUT_TUSER_W = 4;

  // Configuration register indexes
  localparam logic [1:0] CFG_FRAME_LIMIT   = 2'd0;
  localparam logic [1:0] CFG_READING_CMD   = 2'd1;
  localparam logic [1:0] CFG_READING_SUB   = 2'd2;

  // Configuration reset values
  localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RST = 9'd511;
  localparam logic [BYTE_W-1:0]  READING_CMD_RST = 8'h64;  // 'd'
  localparam logic [BYTE_W-1:0]  READING_SUB_RST = 8'h2D;  // '-'

  // Characters of the line format
  localparam logic [BYTE_W-1:0] CH_START = 8'h23;  // '#'
  localparam logic [BYTE_W-1:0] CH_END   = 8'h3B;  // ';'
  localparam logic [BYTE_W-1:0] CH_SEP   = 8'h2C;  // ','
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_CMD,
    PH_SUB,
    PH_COUNT,
    PH_DATA
  } mfpe_phase_t;

  typedef enum logic [1:0] {
    NS_LEAD,
    NS_SIGN,
    NS_DIGITS,
    NS_DONE
  } mfpe_num_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BAD_HEADER,
    ST_COUNT_NONPOS,
    ST_FEW_FIELDS,
    ST_OVERLONG,
    ST_TOO_MANY
  } mfpe_status_t;

  // Finished frame handed from the parser to the energy stage
  typedef struct packed {
    logic [BYTE_W-1:0]  cmd;
    logic [BYTE_W-1:0]  subcmd;
    logic [COUNT_W-1:0] decl;
    logic [VALUE_W-1:0] value;
    mfpe_status_t       status;
    logic               reading;
    logic               accumulate;
    logic [TIME_W-1:0]  dt;
  } mfpe_frame_t;

  function automatic logic is_space(input logic [BYTE_W-1:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage

// File: rtl/meter_frame_parser_energy_unit.sv
// Top level of the meter frame parser with energy integration.
// Holds the configuration registers and the input register; uses mfpe_pkg,
// mfpe_parser and mfpe_energy.
//
//   Port group   Direction  Beat contents
//   s_axis_*     in         one received byte with its arrival time
//   m_axis_*     out        one finished frame with the energy total
//   cfg_*        in         register writes, no read-back
//
// One beat enters per cycle when the output side keeps up. The input register
// feeds the parser and the product multiplier combinationally. m_axis_tvalid
// rises once the closing beat has gone from the input register through the
// product register to the result register, each loading when the next stage
// can take it. A stalled output register holds the pipeline and drops
// s_axis_tready only once all stages are full.
// Synchronous reset clears the frame state, the energy total and the
// configuration registers to their defaults.
`timescale 1ns / 1ps
module meter_frame_parser_energy_unit (
  input  logic                               clk,
  input  logic                               rst,
  // [7:0] rx_byte, [39:8] rx_time_ms
  input  logic [mfpe_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [7:0] frame_cmd, [15:8] frame_subcmd, [23:16] declared_fields,
  // [43:24] first_value, [107:44] energy_total, [111:108] zero
  output logic [mfpe_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [2:0] frame_status, [3] is_reading
  output logic [mfpe_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [mfpe_pkg::LIMIT_W-1:0]       cfg_data
);

  logic [mfpe_pkg::LIMIT_W-1:0] frame_limit;
  logic [mfpe_pkg::BYTE_W-1:0]  reading_command;
  logic [mfpe_pkg::BYTE_W-1:0]  reading_subcommand;

  logic                         in_valid;
  logic [mfpe_pkg::BYTE_W-1:0]  in_byte;
  logic [mfpe_pkg::TIME_W-1:0]  in_time;
  logic                         step;
  logic                         emit;
  logic                         frame_ready;
  mfpe_pkg::mfpe_frame_t        frame;
  mfpe_pkg::mfpe_frame_t        res_frame;
  logic [mfpe_pkg::ENERGY_W-1:0] res_energy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit        <= mfpe_pkg::FRAME_LIMIT_RST;
      reading_command    <= mfpe_pkg::READING_CMD_RST;
      reading_subcommand <= mfpe_pkg::READING_SUB_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mfpe_pkg::CFG_FRAME_LIMIT: frame_limit        <= cfg_data;
        mfpe_pkg::CFG_READING_CMD: reading_command    <= cfg_data[mfpe_pkg::BYTE_W-1:0];
        mfpe_pkg::CFG_READING_SUB: reading_subcommand <= cfg_data[mfpe_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register; a byte is parsed once the product stage can take a result
  assign step          = in_valid && frame_ready;
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata[mfpe_pkg::BYTE_W-1:0];
      in_time <= s_axis_tdata[mfpe_pkg::BYTE_W +: mfpe_pkg::TIME_W];
    end
  end

  mfpe_parser u_parser (
    .clk                (clk),
    .rst                (rst),
    .step               (step),
    .rx_byte            (in_byte),
    .rx_time_ms         (in_time),
    .frame_limit        (frame_limit),
    .reading_command    (reading_command),
    .reading_subcommand (reading_subcommand),
    .emit               (emit),
    .frame              (frame)
  );

  mfpe_energy u_energy (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (step && emit),
    .frame       (frame),
    .frame_ready (frame_ready),
    .res_valid   (m_axis_tvalid),
    .res_ready   (m_axis_tready),
    .res_frame   (res_frame),
    .res_energy  (res_energy)
  );

  // Output packing
  assign m_axis_tdata = {4'b0000, res_energy, res_frame.value, res_frame.decl,
                         res_frame.subcmd, res_frame.cmd};
  assign m_axis_tuser = {res_frame.reading, res_frame.status};

endmodule

// File: rtl/mfpe_parser.sv
// Byte-serial frame parser: start/end mark hunting, header capture, count and
// first value scanning, frame status and reading time bookkeeping.
// Depends on mfpe_pkg.
`timescale 1ns / 1ps
module mfpe_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [mfpe_pkg::BYTE_W-1:0]  rx_byte,
  input  logic [mfpe_pkg::TIME_W-1:0]  rx_time_ms,
  input  logic [mfpe_pkg::LIMIT_W-1:0] frame_limit,
  input  logic [mfpe_pkg::BYTE_W-1:0]  reading_command,
  input  logic [mfpe_pkg::BYTE_W-1:0]  reading_subcommand,
  output logic                         emit,
  output mfpe_pkg::mfpe_frame_t        frame
);

  localparam int CNT_WIDE_W = mfpe_pkg::COUNT_W + 4;
  localparam int VAL_WIDE_W = mfpe_pkg::VALUE_W + 4;
  localparam logic [VAL_WIDE_W-1:0] VALUE_MAX_WIDE =
    VAL_WIDE_W'((64'd1 << mfpe_pkg::VALUE_W) - 64'd1);
  localparam logic [CNT_WIDE_W-1:0] COUNT_MAX_WIDE = CNT_WIDE_W'(255);

  mfpe_pkg::mfpe_phase_t               parse_phase, parse_phase_next;
  mfpe_pkg::mfpe_num_t                 num_stage, num_stage_next;
  logic [mfpe_pkg::LIMIT_W-1:0]        frame_bytes, frame_bytes_next;
  logic [mfpe_pkg::COUNT_W-1:0]        field_index, field_index_next;
  logic                                first_char_seen, first_char_seen_next;
  logic [mfpe_pkg::BYTE_W-1:0]         cmd_char, cmd_char_next;
  logic [mfpe_pkg::BYTE_W-1:0]         subcmd_char, subcmd_char_next;
  logic [mfpe_pkg::COUNT_W-1:0]        count_accum, count_accum_next;
  logic                                count_negative, count_negative_next;
  logic [mfpe_pkg::VALUE_W-1:0]        value_accum, value_accum_next;
  logic [mfpe_pkg::TIME_W-1:0]         last_reading_time, last_reading_time_next;
  logic                                have_last_reading, have_last_reading_next;

  logic [3:0]                   digit;
  logic [CNT_WIDE_W-1:0]        cnt_wide;
  logic [VAL_WIDE_W-1:0]        val_wide;
  logic [mfpe_pkg::COUNT_W-1:0] decl;
  logic                         hdr_match;

  assign digit    = 4'(rx_byte - mfpe_pkg::CH_ZERO);
  assign cnt_wide = CNT_WIDE_W'(count_accum) * CNT_WIDE_W'(10) + CNT_WIDE_W'(digit);
  assign val_wide = VAL_WIDE_W'(value_accum) * VAL_WIDE_W'(10) + VAL_WIDE_W'(digit);
  assign decl     = count_negative ? '0 : count_accum;
  assign hdr_match = (cmd_char == reading_command) && (subcmd_char == reading_subcommand);

  // Next state and frame result for the byte in hand
  always_comb begin
    parse_phase_next       = parse_phase;
    num_stage_next         = num_stage;
    frame_bytes_next       = frame_bytes;
    field_index_next       = field_index;
    first_char_seen_next   = first_char_seen;
    cmd_char_next          = cmd_char;
    subcmd_char_next       = subcmd_char;
    count_accum_next       = count_accum;
    count_negative_next    = count_negative;
    value_accum_next       = value_accum;
    last_reading_time_next = last_reading_time;
    have_last_reading_next = have_last_reading;
    emit                   = 1'b0;
    frame.cmd              = cmd_char;
    frame.subcmd           = subcmd_char;
    frame.decl             = '0;
    frame.value            = '0;
    frame.status           = mfpe_pkg::ST_OK;
    frame.reading          = 1'b0;
    frame.accumulate       = 1'b0;
    frame.dt               = rx_time_ms - last_reading_time;

    if (parse_phase == mfpe_pkg::PH_HUNT) begin
      // Waiting for a start mark; it clears the frame state
      if (rx_byte == mfpe_pkg::CH_START) begin
        parse_phase_next     = mfpe_pkg::PH_CMD;
        frame_bytes_next     = mfpe_pkg::LIMIT_W'(1);
        field_index_next     = '0;
        first_char_seen_next = 1'b0;
        cmd_char_next        = '0;
        subcmd_char_next     = '0;
        count_accum_next     = '0;
        count_negative_next  = 1'b0;
        value_accum_next     = '0;
        num_stage_next       = mfpe_pkg::NS_LEAD;
      end
    end else if (frame_bytes >= frame_limit) begin
      // Overlong frame is reported with the overlong status and abandoned
      emit             = 1'b1;
      frame.status     = mfpe_pkg::ST_OVERLONG;
      parse_phase_next = mfpe_pkg::PH_HUNT;
    end else begin
      frame_bytes_next = frame_bytes + 1'b1;
      unique case (parse_phase)
        mfpe_pkg::PH_CMD, mfpe_pkg::PH_SUB: begin
          // First character of the field is kept, whatever it is
          if (!first_char_seen) begin
            if (parse_phase == mfpe_pkg::PH_CMD) cmd_char_next = rx_byte;
            else subcmd_char_next = rx_byte;
            first_char_seen_next = 1'b1;
          end
          frame.cmd    = cmd_char_next;
          frame.subcmd = subcmd_char_next;
          if (rx_byte == mfpe_pkg::CH_END) begin
            emit             = 1'b1;
            frame.status     = mfpe_pkg::ST_BAD_HEADER;
            parse_phase_next = mfpe_pkg::PH_HUNT;
          end else if (rx_byte == mfpe_pkg::CH_SEP) begin
            parse_phase_next = (parse_phase == mfpe_pkg::PH_CMD) ?
                               mfpe_pkg::PH_SUB : mfpe_pkg::PH_COUNT;
            first_char_seen_next = 1'b0;
            num_stage_next       = mfpe_pkg::NS_LEAD;
          end
        end
        mfpe_pkg::PH_COUNT: begin
          if (rx_byte == mfpe_pkg::CH_END) begin
            emit             = 1'b1;
            frame.status     = mfpe_pkg::ST_BAD_HEADER;
            parse_phase_next = mfpe_pkg::PH_HUNT;
          end else if (rx_byte == mfpe_pkg::CH_SEP) begin
            parse_phase_next = mfpe_pkg::PH_DATA;
            field_index_next = '0;
            num_stage_next   = mfpe_pkg::NS_LEAD;
          end else if ((num_stage == mfpe_pkg::NS_LEAD) && mfpe_pkg::is_space(rx_byte)) begin
            num_stage_next = num_stage;
          end else if ((num_stage == mfpe_pkg::NS_LEAD) &&
                       ((rx_byte == mfpe_pkg::CH_PLUS) || (rx_byte == mfpe_pkg::CH_MINUS))) begin
            count_negative_next = (rx_byte == mfpe_pkg::CH_MINUS);
            num_stage_next      = mfpe_pkg::NS_SIGN;
          end else if ((num_stage != mfpe_pkg::NS_DONE) && mfpe_pkg::is_digit(rx_byte)) begin
            count_accum_next = (cnt_wide > COUNT_MAX_WIDE) ? '1 :
                               mfpe_pkg::COUNT_W'(cnt_wide);
            num_stage_next   = mfpe_pkg::NS_DIGITS;
          end else begin
            num_stage_next = mfpe_pkg::NS_DONE;
          end
        end
        mfpe_pkg::PH_DATA: begin
          if (rx_byte == mfpe_pkg::CH_END) begin
            // End of frame: check the count against the fields seen
            emit             = 1'b1;
            parse_phase_next = mfpe_pkg::PH_HUNT;
            frame.decl       = decl;
            if (decl == '0) begin
              frame.status = mfpe_pkg::ST_COUNT_NONPOS;
            end else if (decl > mfpe_pkg::COUNT_W'(mfpe_pkg::MAX_FIELDS)) begin
              frame.status = mfpe_pkg::ST_TOO_MANY;
            end else if ((9'(field_index) + 9'd2) < 9'(decl)) begin
              frame.status = mfpe_pkg::ST_FEW_FIELDS;
            end else begin
              frame.status  = mfpe_pkg::ST_OK;
              frame.value   = value_accum;
              frame.reading = hdr_match;
              if (hdr_match) begin
                frame.accumulate       = have_last_reading;
                last_reading_time_next = rx_time_ms;
                have_last_reading_next = 1'b1;
              end
            end
          end else if (rx_byte == mfpe_pkg::CH_SEP) begin
            if (field_index != '1) field_index_next = field_index + 1'b1;
          end else if (field_index == '0) begin
            if ((num_stage == mfpe_pkg::NS_LEAD) && mfpe_pkg::is_space(rx_byte)) begin
              num_stage_next = num_stage;
            end else if ((num_stage != mfpe_pkg::NS_DONE) && mfpe_pkg::is_digit(rx_byte)) begin
              value_accum_next = (val_wide > VALUE_MAX_WIDE) ? '1 :
                                 mfpe_pkg::VALUE_W'(val_wide);
              num_stage_next   = mfpe_pkg::NS_DIGITS;
            end else begin
              num_stage_next = mfpe_pkg::NS_DONE;
            end
          end
        end
        default: begin
          parse_phase_next = mfpe_pkg::PH_HUNT;
        end
      endcase
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase       <= mfpe_pkg::PH_HUNT;
      num_stage         <= mfpe_pkg::NS_LEAD;
      frame_bytes       <= '0;
      field_index       <= '0;
      first_char_seen   <= 1'b0;
      cmd_char          <= '0;
      subcmd_char       <= '0;
      count_accum       <= '0;
      count_negative    <= 1'b0;
      value_accum       <= '0;
      last_reading_time <= '0;
      have_last_reading <= 1'b0;
    end else if (step) begin
      parse_phase       <= parse_phase_next;
      num_stage         <= num_stage_next;
      frame_bytes       <= frame_bytes_next;
      field_index       <= field_index_next;
      first_char_seen   <= first_char_seen_next;
      cmd_char          <= cmd_char_next;
      subcmd_char       <= subcmd_char_next;
      count_accum       <= count_accum_next;
      count_negative    <= count_negative_next;
      value_accum       <= value_accum_next;
      last_reading_time <= last_reading_time_next;
      have_last_reading <= have_last_reading_next;
    end
  end

endmodule

// File: rtl/mfpe_energy.sv
// Energy stage: power times elapsed time into a product register, then a
// saturating 64-bit accumulate into the result register.
// Depends on mfpe_pkg.
`timescale 1ns / 1ps
module mfpe_energy (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           frame_valid,
  input  mfpe_pkg::mfpe_frame_t          frame,
  output logic                           frame_ready,
  output logic                           res_valid,
  input  logic                           res_ready,
  output mfpe_pkg::mfpe_frame_t          res_frame,
  output logic [mfpe_pkg::ENERGY_W-1:0]  res_energy
);

  logic                            mul_valid;
  mfpe_pkg::mfpe_frame_t           mul_frame;
  logic [mfpe_pkg::PRODUCT_W-1:0]  mul_product;
  logic                            mul_advance;
  logic [mfpe_pkg::ENERGY_W-1:0]   energy_accum, energy_accum_next;
  logic [mfpe_pkg::ENERGY_W:0]     energy_sum;

  assign mul_advance = mul_valid && (!res_valid || res_ready);
  assign frame_ready = !mul_valid || mul_advance;

  // Saturating add of the registered product
  assign energy_sum = {1'b0, energy_accum} +
                      (mfpe_pkg::ENERGY_W + 1)'(mul_product);
  assign energy_accum_next = energy_sum[mfpe_pkg::ENERGY_W] ? '1 :
                             energy_sum[mfpe_pkg::ENERGY_W-1:0];

  // Product stage: zero unless the frame adds energy
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (frame_ready) begin
      mul_valid <= frame_valid;
    end
    if (frame_ready && frame_valid) begin
      mul_frame   <= frame;
      mul_product <= frame.accumulate ?
                     mfpe_pkg::PRODUCT_W'(frame.value) * mfpe_pkg::PRODUCT_W'(frame.dt) :
                     '0;
    end
  end

  // Accumulator and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      energy_accum <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (mul_advance) begin
        energy_accum <= energy_accum_next;
      end
      if (!res_valid || res_ready) begin
        res_valid <= mul_valid;
      end
    end
    if (mul_advance) begin
      res_frame  <= mul_frame;
      res_energy <= energy_accum_next;
    end
  end

endmodule

// File: tb/tb_meter_frame_parser_energy_unit.sv
// Self-checking testbench for meter_frame_parser_energy_unit.
// Sends byte beats, predicts every finished frame and checks each output beat.
// Depends only on mfpe_pkg and the unit's RTL.
`timescale 1ns / 1ps
module tb_meter_frame_parser_energy_unit;
  import mfpe_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 8;
  localparam int FULL_FRAMES = 20;
  localparam longint VAL_MAX = (longint'(1) << VALUE_W) - 1;

  // Placeholders in the directed table for bytes that a string cannot hold.
  localparam logic [BYTE_W-1:0] MARK_FF  = "~";
  localparam logic [BYTE_W-1:0] MARK_NUL = "^";

  typedef struct packed {
    logic [BYTE_W-1:0]   cmd;
    logic [BYTE_W-1:0]   subcmd;
    logic [COUNT_W-1:0]  decl;
    logic [VALUE_W-1:0]  value;
    mfpe_status_t        status;
    logic                reading;
    logic [ENERGY_W-1:0] energy;
  } frame_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [1:0]             cfg_index = CFG_FRAME_LIMIT;
  logic [LIMIT_W-1:0]     cfg_data = '0;

  // Typed status of a directed row, carried alongside its closing beat.
  logic         dir_tag = 1'b0;
  mfpe_status_t dir_status = ST_OK;
  logic         dir_reading = 1'b0;

  // Directed table: one frame per row.
  localparam int DIR_ROWS = 6;
  string        dir_text [DIR_ROWS] = '{"#d,-,1,7;", "#;", "#~,^,0,;", "#,,3,;",
                                        "#,,19,;", "#d,-,1,9;"};
  logic [31:0]  dir_stamp [DIR_ROWS] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555,
                                         32'hAAAA_AAAA, 32'h0000_0001, 32'hFFFF_FFFF};
  mfpe_status_t dir_want_st [DIR_ROWS] = '{ST_OK, ST_BAD_HEADER, ST_COUNT_NONPOS,
                                           ST_FEW_FIELDS, ST_TOO_MANY, ST_OK};
  logic         dir_want_rd [DIR_ROWS] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};

  // Frame tracker state and its copy of the registers.
  logic [LIMIT_W-1:0]  lim_q;
  logic [BYTE_W-1:0]   rd_cmd_q, rd_sub_q;
  mfpe_phase_t         pr_phase;
  mfpe_num_t           pr_num;
  logic [LIMIT_W-1:0]  pr_bytes;
  logic [7:0]          pr_field;
  logic                pr_first_seen;
  logic [BYTE_W-1:0]   pr_cmd, pr_sub;
  logic [COUNT_W-1:0]  pr_count;
  logic                pr_neg;
  logic [VALUE_W-1:0]  pr_value;
  logic [ENERGY_W-1:0] pr_energy;
  logic [TIME_W-1:0]   pr_last_time;
  logic                pr_have_last;

  frame_result_t frames_due [$];
  int            bad_count = 0;
  int            cycle_count = 0;
  int            hold_left = 0;
  bit            send_idle = 1'b1;
  bit            recv_idle = 1'b1;

  // Generator side: register values in force and the line being built.
  logic [LIMIT_W-1:0] gen_lim = FRAME_LIMIT_RST;
  logic [BYTE_W-1:0]  gen_cmd = READING_CMD_RST;
  logic [BYTE_W-1:0]  gen_sub = READING_SUB_RST;
  logic [TIME_W-1:0]  clock_ms = 32'd1000;
  logic [BYTE_W-1:0]  line_buf [$];

  meter_frame_parser_energy_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic is_blank(input logic [BYTE_W-1:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic is_dec(input logic [BYTE_W-1:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // Queue one finished frame and go back to hunting for a start mark.
  function automatic void note_frame(input logic [COUNT_W-1:0] decl,
                                     input logic [VALUE_W-1:0] value,
                                     input mfpe_status_t status, input logic reading);
    frame_result_t r;
    r.cmd     = pr_cmd;
    r.subcmd  = pr_sub;
    r.decl    = decl;
    r.value   = value;
    r.status  = status;
    r.reading = reading;
    r.energy  = pr_energy;
    frames_due.push_back(r);
    pr_phase = PH_HUNT;
  endfunction

  // Advance the frame tracker by one received byte.
  function automatic void track_meter_byte(input logic [BYTE_W-1:0] b,
                                           input logic [TIME_W-1:0] now);
    int                  acc;
    longint              lv;
    logic [COUNT_W-1:0]  decl;
    mfpe_status_t        st;
    logic [TIME_W-1:0]   dt;
    logic [ENERGY_W-1:0] prod;
    logic [ENERGY_W:0]   sum;
    if (pr_phase == PH_HUNT) begin
      if (b == CH_START) begin
        pr_phase      = PH_CMD;
        pr_bytes      = 1;
        pr_field      = 0;
        pr_first_seen = 1'b0;
        pr_cmd        = 0;
        pr_sub        = 0;
        pr_count      = 0;
        pr_neg        = 1'b0;
        pr_value      = 0;
        pr_num        = NS_LEAD;
      end
      return;
    end
    // The byte that would push the frame past the limit is swallowed.
    if (pr_bytes >= lim_q) begin
      note_frame(0, 0, ST_OVERLONG, 1'b0);
      return;
    end
    pr_bytes = pr_bytes + 1'b1;
    case (pr_phase)
      PH_CMD, PH_SUB: begin
        if (!pr_first_seen) begin
          if (pr_phase == PH_CMD) pr_cmd = b;
          else pr_sub = b;
          pr_first_seen = 1'b1;
        end
        if (b == CH_END) begin
          note_frame(0, 0, ST_BAD_HEADER, 1'b0);
        end else if (b == CH_SEP) begin
          pr_phase      = (pr_phase == PH_CMD) ? PH_SUB : PH_COUNT;
          pr_first_seen = 1'b0;
          pr_num        = NS_LEAD;
        end
      end
      PH_COUNT: begin
        if (b == CH_END) begin
          note_frame(0, 0, ST_BAD_HEADER, 1'b0);
        end else if (b == CH_SEP) begin
          pr_phase = PH_DATA;
          pr_field = 0;
          pr_num   = NS_LEAD;
        end else if (!(pr_num == NS_LEAD && is_blank(b))) begin
          // Signed decimal count, saturating at 255.
          if (pr_num == NS_LEAD && (b == CH_PLUS || b == CH_MINUS)) begin
            pr_neg = (b == CH_MINUS);
            pr_num = NS_SIGN;
          end else if (pr_num != NS_DONE && is_dec(b)) begin
            acc      = int'(pr_count) * 10 + int'(b) - int'(CH_ZERO);
            pr_count = (acc > 255) ? 8'd255 : acc[7:0];
            pr_num   = NS_DIGITS;
          end else begin
            pr_num = NS_DONE;
          end
        end
      end
      default: begin
        if (b == CH_END) begin
          decl = pr_neg ? 8'd0 : pr_count;
          if (decl == 0) st = ST_COUNT_NONPOS;
          else if (int'(decl) > MAX_FIELDS) st = ST_TOO_MANY;
          else if (int'(pr_field) + 2 < int'(decl)) st = ST_FEW_FIELDS;
          else st = ST_OK;
          if (st != ST_OK) begin
            note_frame(decl, 0, st, 1'b0);
          end else if (pr_cmd == rd_cmd_q && pr_sub == rd_sub_q) begin
            // Power reading: integrate over the time since the previous one.
            if (pr_have_last) begin
              dt        = now - pr_last_time;
              prod      = 64'(pr_value) * 64'(dt);
              sum       = {1'b0, pr_energy} + {1'b0, prod};
              pr_energy = sum[ENERGY_W] ? '1 : sum[ENERGY_W-1:0];
            end
            pr_last_time = now;
            pr_have_last = 1'b1;
            note_frame(decl, pr_value, ST_OK, 1'b1);
          end else begin
            note_frame(decl, pr_value, ST_OK, 1'b0);
          end
        end else if (b == CH_SEP) begin
          if (pr_field < 8'd255) pr_field = pr_field + 1'b1;
        end else if (pr_field == 0 && !(pr_num == NS_LEAD && is_blank(b))) begin
          // Unsigned decimal value of the first data field, saturating.
          if (pr_num != NS_DONE && is_dec(b)) begin
            lv       = longint'(pr_value) * 10 + longint'(b) - longint'(CH_ZERO);
            pr_value = (lv > VAL_MAX) ? VAL_MAX[VALUE_W-1:0] : lv[VALUE_W-1:0];
            pr_num   = NS_DIGITS;
          end else begin
            pr_num = NS_DONE;
          end
        end
      end
    endcase
  endfunction

  // Check output beats, follow register writes and track accepted input beats.
  always @(posedge clk) begin : monitor_p
    frame_result_t got, want;
    int            due_before;
    if (rst) begin
      lim_q         = FRAME_LIMIT_RST;
      rd_cmd_q      = READING_CMD_RST;
      rd_sub_q      = READING_SUB_RST;
      pr_phase      = PH_HUNT;
      pr_num        = NS_LEAD;
      pr_bytes      = 0;
      pr_field      = 0;
      pr_first_seen = 1'b0;
      pr_cmd        = 0;
      pr_sub        = 0;
      pr_count      = 0;
      pr_neg        = 1'b0;
      pr_value      = 0;
      pr_energy     = 0;
      pr_last_time  = 0;
      pr_have_last  = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.cmd     = m_axis_tdata[7:0];
        got.subcmd  = m_axis_tdata[15:8];
        got.decl    = m_axis_tdata[23:16];
        got.value   = m_axis_tdata[43:24];
        got.energy  = m_axis_tdata[107:44];
        got.status  = mfpe_status_t'(m_axis_tuser[2:0]);
        got.reading = m_axis_tuser[3];
        if (frames_due.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: output beat with no frame pending: tdata=%h tuser=%h",
                     $time, m_axis_tdata, m_axis_tuser);
        end else begin
          want = frames_due.pop_front();
          if (got.cmd !== want.cmd || got.subcmd !== want.subcmd ||
              got.decl !== want.decl || got.value !== want.value ||
              got.status !== want.status || got.reading !== want.reading ||
              got.energy !== want.energy) begin
            bad_count++;
            if (bad_count <= 10) begin
              $display("%0t: frame mismatch", $time);
              $display("  want cmd=%h sub=%h decl=%0d value=%0d status=%0d reading=%b energy=%h",
                       want.cmd, want.subcmd, want.decl, want.value, want.status,
                       want.reading, want.energy);
              $display("  got  cmd=%h sub=%h decl=%0d value=%0d status=%0d reading=%b energy=%h",
                       got.cmd, got.subcmd, got.decl, got.value, got.status,
                       got.reading, got.energy);
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_LIMIT: lim_q    = cfg_data;
          CFG_READING_CMD: rd_cmd_q = cfg_data[BYTE_W-1:0];
          CFG_READING_SUB: rd_sub_q = cfg_data[BYTE_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        due_before = frames_due.size();
        track_meter_byte(s_axis_tdata[BYTE_W-1:0], s_axis_tdata[BYTE_W +: TIME_W]);
        // A directed row's closing beat carries the status typed in the table.
        if (dir_tag && frames_due.size() > due_before) begin
          want         = frames_due.pop_back();
          want.status  = dir_status;
          want.reading = dir_reading;
          frames_due.push_back(want);
        end
      end
    end
  end

  // Output side back-pressure in short random bursts.
  always @(posedge clk) begin
    if (recv_idle && hold_left == 0 && $urandom_range(0, 5) == 0)
      hold_left = $urandom_range(1, 4);
    if (recv_idle && hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_meter_frame_parser_energy_unit: done, errors");
      $finish;
    end
  end

  // Present one byte beat and hold it until it is taken.
  task automatic send_line_byte(input logic [BYTE_W-1:0] b, input logic [TIME_W-1:0] stamp,
                                input logic tag, input mfpe_status_t st, input logic rd);
    if (send_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tdata  <= {stamp, b};
    s_axis_tvalid <= 1'b1;
    dir_tag       <= tag;
    dir_status    <= st;
    dir_reading   <= rd;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stop sending until every pending frame is out, then let the pipe settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (frames_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [LIMIT_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_FRAME_LIMIT: gen_lim = val;
      CFG_READING_CMD: gen_cmd = val[BYTE_W-1:0];
      default:         gen_sub = val[BYTE_W-1:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all_regs(input logic [LIMIT_W-1:0] lim, input logic [BYTE_W-1:0] cmd,
                              input logic [BYTE_W-1:0] sub);
    set_reg(CFG_FRAME_LIMIT, lim);
    set_reg(CFG_READING_CMD, {1'b0, cmd});
    set_reg(CFG_READING_SUB, {1'b0, sub});
  endtask

  function automatic logic [BYTE_W-1:0] any_plain_byte();
    logic [BYTE_W-1:0] c;
    do c = $urandom_range(0, 255); while (c == CH_SEP || c == CH_END);
    return c;
  endfunction

  function automatic void push_decimal(input longint unsigned v);
    logic [BYTE_W-1:0] rev [$];
    do begin
      rev.push_back(8'(CH_ZERO + v % 10));
      v = v / 10;
    end while (v != 0);
    while (rev.size() != 0) line_buf.push_back(rev.pop_back());
  endfunction

  function automatic void push_blanks(input int n);
    logic [BYTE_W-1:0] c;
    repeat (n) begin
      c = $urandom_range(8, 13);
      line_buf.push_back((c == 8) ? CH_SPACE : c);
    end
  endfunction

  // Command or subcommand field: mostly the reading character, at times empty or another byte.
  function automatic void add_head_field(input logic [BYTE_W-1:0] want);
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) line_buf.push_back(want);
    else if (r >= 80) line_buf.push_back(any_plain_byte());
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 2)) line_buf.push_back(any_plain_byte());
    line_buf.push_back(CH_SEP);
  endfunction

  // Build one line: mostly well-formed frames with random content, some noise
  // and some frames with a corrupted byte.
  function automatic void build_random_line();
    int r, cnt, nf, pos;
    line_buf.delete();
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    line_buf.push_back(CH_START);
    add_head_field(gen_cmd);
    add_head_field(gen_sub);
    // Count field with optional blanks, sign and trailing junk.
    if ($urandom_range(0, 4) == 0) push_blanks($urandom_range(1, 2));
    r = $urandom_range(0, 99);
    if (r < 6) line_buf.push_back(CH_MINUS);
    else if (r < 10) line_buf.push_back(CH_PLUS);
    r = $urandom_range(0, 99);
    if (r < 70) cnt = $urandom_range(1, MAX_FIELDS);
    else if (r < 78) cnt = 0;
    else if (r < 90) cnt = $urandom_range(MAX_FIELDS + 1, 60);
    else if (r < 96) cnt = $urandom_range(200, 999);
    else cnt = -1;
    if (cnt >= 0) begin
      if ($urandom_range(0, 9) == 0) line_buf.push_back(CH_ZERO);
      push_decimal(cnt);
    end
    if ($urandom_range(0, 19) == 0) line_buf.push_back(any_plain_byte());
    line_buf.push_back(CH_SEP);
    // Number of data fields, clustered around the declared count.
    if (cnt >= 1 && cnt <= MAX_FIELDS) begin
      r = $urandom_range(0, 99);
      if (r < 40) nf = cnt - 1;
      else if (r < 60) nf = cnt;
      else if (r < 75) nf = cnt - 2;
      else nf = $urandom_range(1, cnt + 2);
    end else begin
      nf = $urandom_range(1, 4);
    end
    if (nf < 1) nf = 1;
    // First data field carries the value.
    if ($urandom_range(0, 6) == 0) push_blanks($urandom_range(1, 3));
    r = $urandom_range(0, 99);
    if (r < 50) push_decimal($urandom_range(0, 9999));
    else if (r < 75) push_decimal($urandom_range(0, 1048575));
    else if (r < 90) push_decimal($urandom_range(1000000, 99999999));
    if ($urandom_range(0, 9) == 0) begin
      line_buf.push_back(any_plain_byte());
      push_decimal($urandom_range(0, 99));
    end
    repeat (nf - 1) begin
      line_buf.push_back(CH_SEP);
      if ($urandom_range(0, 1) == 0) push_decimal($urandom_range(0, 999));
    end
    // Now and then a very long tail so that large limits are reached.
    if ($urandom_range(0, 59) == 0)
      repeat ($urandom_range(200, 560))
        line_buf.push_back(($urandom_range(0, 3) == 0) ? CH_SEP : CH_ZERO + 8'd7);
    line_buf.push_back(CH_END);
    if ($urandom_range(0, 9) == 0) begin
      pos = $urandom_range(1, line_buf.size() - 1);
      r   = $urandom_range(0, 3);
      line_buf[pos] = (r == 0) ? CH_END : (r == 1) ? CH_SEP : (r == 2) ? CH_START
                    : 8'($urandom_range(0, 255));
    end
  endfunction

  task automatic send_line(input bit drift);
    int i;
    for (i = 0; i < line_buf.size(); i++) begin
      send_line_byte(line_buf[i], clock_ms, 1'b0, ST_OK, 1'b0);
      if (drift) clock_ms = clock_ms + $urandom_range(0, 2);
    end
  endtask

  task automatic run_random(input int target);
    int sent;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 19) == 0) clock_ms = $urandom();
      else clock_ms = clock_ms + $urandom_range(0, 3000);
      build_random_line();
      sent += line_buf.size();
      send_line(1'b1);
    end
  endtask

  initial begin : stimulus_p
    int                i, k;
    logic [BYTE_W-1:0] c;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed frames under the reset register values.
    for (i = 0; i < DIR_ROWS; i++) begin
      for (k = 0; k < dir_text[i].len(); k++) begin
        c = dir_text[i][k];
        if (c == MARK_FF) c = 8'hFF;
        else if (c == MARK_NUL) c = 8'h00;
        send_line_byte(c, dir_stamp[i], k == dir_text[i].len() - 1,
                       dir_want_st[i], dir_want_rd[i]);
      end
    end
    run_random(300);
    wait_drained();

    // Smallest frame limit.
    set_all_regs(9'd8, READING_CMD_RST, READING_SUB_RST);
    run_random(250);
    wait_drained();

    // Largest limit with extreme reading characters, drained halfway.
    set_all_regs(9'd511, 8'hFF, 8'h00);
    run_random(125);
    wait_drained();
    run_random(125);
    wait_drained();

    // Random setting.
    set_all_regs($urandom_range(9, 60), $urandom_range(0, 255), $urandom_range(0, 255));
    run_random(250);
    wait_drained();

    // Last part without idling: full-scale readings whose stamps step back by one
    // millisecond wrap to the largest elapsed time and give the widest products.
    send_idle = 1'b0;
    recv_idle = 1'b0;
    set_all_regs(9'd24, READING_CMD_RST, READING_SUB_RST);
    repeat (FULL_FRAMES) begin
      line_buf.delete();
      line_buf.push_back(CH_START);
      line_buf.push_back(gen_cmd);
      line_buf.push_back(CH_SEP);
      line_buf.push_back(gen_sub);
      line_buf.push_back(CH_SEP);
      push_decimal(1);
      line_buf.push_back(CH_SEP);
      push_decimal(VAL_MAX);
      line_buf.push_back(CH_END);
      clock_ms = clock_ms - 1'b1;
      send_line(1'b0);
    end
    run_random(150);
    wait_drained();

    bad_count += frames_due.size();
    if (bad_count == 0) begin
      $display("tb_meter_frame_parser_energy_unit: done, clean");
    end else begin
      $display("tb_meter_frame_parser_energy_unit: done, errors");
    end
    $finish;
  end

endmodule
